// ----- rtl/rde_pkg.sv -----
// Shared types, constants and the radix divide step for the radix digit expander.
// No dependencies; used by radix_digit_expander and rde_checker.
package rde_pkg;

    localparam int VALUE_W    = 63;
    localparam int RADIX_W    = 4;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int POS_W      = 6;
    localparam int STEP_BITS  = 4;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_EMIT,
        ST_DELIVER
    } rde_state_t;

    typedef struct packed {
        logic [DIGIT_W-1:0]   rem;
        logic [STEP_BITS-1:0] qbits;
    } div_step_t;

    // Four restoring steps of long division by a small base.
    // Remainder in stays below base, so five bits hold every partial value.
    function automatic div_step_t div_step(
        input logic [DIGIT_W-1:0]   rem,
        input logic [STEP_BITS-1:0] nib,
        input logic [RADIX_W-1:0]   base
    );
        div_step_t          res;
        logic [DIGIT_W:0]   r;
        r         = {1'b0, rem};
        res.qbits = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--)
        begin
            r = {r[DIGIT_W-1:0], nib[i]};
            if (r >= {1'b0, base})
            begin
                r            = r - {1'b0, base};
                res.qbits[i] = 1'b1;
            end
        end
        res.rem = r[DIGIT_W-1:0];
        return res;
    endfunction

endpackage

// ----- rtl/radix_digit_expander.sv -----
// Radix digit expander top level: sequencer around one shared divide-by-base step.
// Depends on rde_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / value) takes one non-negative integer.
//   Output channel (out_valid / out_stall / digit, digit_char, position, last,
//   magnitude) returns one transfer per digit, least significant first; last
//   marks the most significant digit. A zero value gives one digit 0 with
//   magnitude 0. cfg_wr_en / cfg_wr_data write the radix (0,1 act as 2;
//   11..15 act as 10); write it only while the block is idle.
//   Timing: the divide step retires 4 dividend bits per cycle; one division
//   covers NCHUNK = ceil(VALUE_BITS/4) chunks (16 at the default). A value with
//   M digits first runs M divisions to count digits, then M more to emit them,
//   each digit then being loaded into the output register. in_stall stays
//   high from the input transfer until the last digit is loaded into the
//   output register.
//   Reset clears the sequencer and output valid and sets the radix to 10.
//   A stalled output holds its digit; the divider waits until the output
//   register frees up.
module radix_digit_expander #(
    parameter int VALUE_BITS = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rde_pkg::RADIX_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rde_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rde_pkg::DIGIT_W-1:0]   digit,
    output logic [rde_pkg::CHAR_W-1:0]    digit_char,
    output logic [rde_pkg::POS_W-1:0]     position,
    output logic                          last,
    output logic [rde_pkg::POS_W-1:0]     magnitude
);
    import rde_pkg::*;

    localparam int NCHUNK = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DW     = NCHUNK * STEP_BITS;
    localparam int CNT_W  = $clog2(NCHUNK);

    rde_state_t          state_reg, state_next;
    logic [RADIX_W-1:0]  radix_reg;
    logic [RADIX_W-1:0]  base_reg, base_next;
    logic [DW-1:0]       x_reg, x_next;
    logic [DW-1:0]       t_reg, t_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [POS_W-1:0]    mag_reg, mag_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic                out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]  digit_reg, digit_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic                last_reg, last_next;
    logic [POS_W-1:0]    magnitude_reg, magnitude_next;

    div_step_t           step;
    logic [DW-1:0]       t_shift;
    logic [DW-1:0]       in_val;
    logic [RADIX_W-1:0]  eff_base;
    logic                div_done;
    logic                slot_free;
    logic                is_last;

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            eff_base = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            eff_base = RADIX_MAX;
        else
            eff_base = radix_reg;
    end

    assign in_val    = DW'(value[VALUE_BITS-1:0]);
    assign step      = div_step(rem_reg, t_reg[DW-1 -: STEP_BITS], base_reg);
    assign t_shift   = {t_reg[DW-STEP_BITS-1:0], step.qbits};
    assign div_done  = (cnt_reg == CNT_W'(NCHUNK - 1));
    assign slot_free = !out_valid_reg || !out_stall;
    assign is_last   = (POS_W'(pos_reg + 1'b1) == mag_reg) || (mag_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && out_stall;
        digit_next     = digit_reg;
        position_next  = position_reg;
        last_next      = last_reg;
        magnitude_next = magnitude_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next    = in_val;
                    t_next    = in_val;
                    base_next = eff_base;
                    rem_next  = '0;
                    cnt_next  = '0;
                    mag_next  = '0;
                    pos_next  = '0;
                    state_next = (in_val == '0) ? ST_DELIVER : ST_COUNT;
                end
            end
            // first pass: count divisions until the quotient is zero
            ST_COUNT:
            begin
                t_next   = t_shift;
                rem_next = step.rem;
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (div_done)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    mag_next = POS_W'(mag_reg + 1'b1);
                    if (t_shift == '0)
                    begin
                        t_next     = x_reg;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                t_next   = t_shift;
                rem_next = step.rem;
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (div_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = rem_reg;
                    position_next  = pos_reg;
                    last_next      = is_last;
                    magnitude_next = mag_reg;
                    pos_next       = POS_W'(pos_reg + 1'b1);
                    rem_next       = '0;
                    state_next     = is_last ? ST_IDLE : ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                radix_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        x_reg         <= x_next;
        t_reg         <= t_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        mag_reg       <= mag_next;
        pos_reg       <= pos_next;
        digit_reg     <= digit_next;
        position_reg  <= position_next;
        last_reg      <= last_next;
        magnitude_reg <= magnitude_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign digit      = digit_reg;
    assign digit_char = CHAR_W'(ASCII_ZERO + CHAR_W'(digit_reg));
    assign position   = position_reg;
    assign last       = last_reg;
    assign magnitude  = magnitude_reg;

endmodule

// ----- rtl/rde_checker.sv -----
// Port-level checks for radix_digit_expander, bound to the top level below.
// Depends on rde_pkg.
module rde_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [rde_pkg::DIGIT_W-1:0]   digit,
    input  logic [rde_pkg::CHAR_W-1:0]    digit_char,
    input  logic [rde_pkg::POS_W-1:0]     position,
    input  logic                          last,
    input  logic [rde_pkg::POS_W-1:0]     magnitude
);
    import rde_pkg::*;

    // a stalled digit transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digit) && $stable(position)
            && $stable(last) && $stable(magnitude))
        else $error("output changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the item was expanded");

    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_char == CHAR_W'(ASCII_ZERO + CHAR_W'(digit)))
        else $error("digit_char does not match digit");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && magnitude != '0 |-> POS_W'(position + 1'b1) == magnitude)
        else $error("last digit not at top position");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && magnitude == '0 |-> last && digit == '0 && position == '0)
        else $error("zero value result malformed");

endmodule

bind radix_digit_expander rde_checker u_rde_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit      (digit),
    .digit_char (digit_char),
    .position   (position),
    .last       (last),
    .magnitude  (magnitude)
);
